[sv/plis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PHY link init sequencer package
// Shared item types, codes and state record of the sequencer.
// ----------------------------------------------------------------------------
package plis_pkg;

	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_RESP  = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_MDIO_RD   = 2'd0,
		KIND_MDIO_WR   = 2'd1,
		KIND_INIT_STAT = 2'd2,
		KIND_LINK_REP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BUSY   = 2'd1,
		STAT_HW_ERR = 2'd2
	} init_status_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_RST_WR     = 4'd1,
		PH_RST_TICK   = 4'd2,
		PH_RST_RD     = 4'd3,
		PH_AN_TICK    = 4'd4,
		PH_AN_RD      = 4'd5,
		PH_CTL_RD     = 4'd6,
		PH_RA_WR      = 4'd7,
		PH_LU_TICK    = 4'd8,
		PH_LU_RD      = 4'd9,
		PH_UPD_ANAR   = 4'd10,
		PH_UPD_LPANAR = 4'd11,
		PH_UPD_STAT   = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		CFG_PHY_ADDRESS   = 2'd0,
		CFG_RESET_LIMIT   = 2'd1,
		CFG_AUTONEG_LIMIT = 2'd2,
		CFG_LINK_LIMIT    = 2'd3
	} cfg_index_t;

	localparam logic [4:0] REG_CONTROL = 5'd0;
	localparam logic [4:0] REG_STATUS  = 5'd1;
	localparam logic [4:0] REG_ANAR    = 5'd4;
	localparam logic [4:0] REG_LPANAR  = 5'd5;

	localparam logic [15:0] CTL_RESET_CMD = 16'h8000;

	typedef struct packed {
		logic [1:0]  action;
		logic        force_reset;
		logic        refresh;
		logic        mdio_ok;
		logic [15:0] mdio_data;
	} plis_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  dev_addr;
		logic [4:0]  reg_addr;
		logic [15:0] write_data;
		logic [1:0]  status;
		logic [4:0]  link_flags;
	} plis_out_t;

	typedef struct packed {
		logic [4:0]  phy_address;
		logic [15:0] reset_poll_limit;
		logic [15:0] autoneg_poll_limit;
		logic [15:0] link_poll_limit;
	} plis_cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] poll_count;
		logic [15:0] control_copy;
		logic [15:0] status_copy;
		logic [15:0] advert_copy;
		logic [4:0]  link_state;
		logic        init_done;
		logic        busy;
		logic        query_owner;
	} plis_state_t;

	localparam plis_state_t STATE_RESET = '{PH_IDLE, 16'd0, 16'd0, 16'd0, 16'd0,
		5'd0, 1'b0, 1'b0, 1'b0};

	localparam plis_cfg_t CFG_RESET = '{5'd1, 16'd1000, 16'd6000, 16'd1000};

endpackage

[sv/plis_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PHY link init sequencer step logic
// Next state and result item for one event, given the current state.
// ----------------------------------------------------------------------------
module plis_step import plis_pkg::*; (
	input  plis_state_t st,
	input  plis_cfg_t   cfg,
	input  plis_in_t    item,
	output plis_state_t st_next,
	output logic        res_valid,
	output plis_out_t   res
);

	logic [15:0] d;
	logic        ok;
	logic [15:0] ctl_100;
	logic [15:0] ctl_10;
	logic [4:0]  resolved;
	logic        rst_done;
	logic        an_end;
	logic        lu_end;

	assign d        = item.mdio_data;
	assign ok       = item.mdio_ok;
	assign ctl_100  = (d | 16'h2000) & ~16'h0040;
	assign ctl_10   = (d & ~16'h2000) | 16'h0040;
	assign rst_done = st.poll_count >= cfg.reset_poll_limit;
	assign an_end   = d[5] || (st.poll_count >= cfg.autoneg_poll_limit);
	assign lu_end   = !ok || d[2] || (st.poll_count >= cfg.link_poll_limit);

	always_comb begin
		resolved = 5'd0;
		if ((st.advert_copy & 16'h0180) != 16'd0) begin
			resolved[1] = 1'b1;
		end else if ((st.advert_copy & 16'h0060) != 16'd0) begin
			resolved[2] = 1'b1;
		end
		if ((st.advert_copy & 16'h0140) != 16'd0) begin
			resolved[3] = 1'b1;
		end else if ((st.advert_copy & 16'h00A0) != 16'd0) begin
			resolved[4] = 1'b1;
		end
		resolved[0] = d[2];
	end

	function automatic plis_out_t mk(input kind_t k, input logic [4:0] addr,
		input logic [4:0] ra, input logic [15:0] wd, input init_status_t s,
		input logic [4:0] fl);
		plis_out_t o;
		o.kind       = k;
		o.dev_addr   = (k == KIND_MDIO_RD || k == KIND_MDIO_WR) ? addr : 5'd0;
		o.reg_addr   = (k == KIND_MDIO_RD || k == KIND_MDIO_WR) ? ra : 5'd0;
		o.write_data = (k == KIND_MDIO_WR) ? wd : 16'd0;
		o.status     = (k == KIND_INIT_STAT) ? s : STAT_OK;
		o.link_flags = (k == KIND_LINK_REP) ? fl : 5'd0;
		return o;
	endfunction

	// Next state.
	always_comb begin
		st_next = st;
		case (item.action)
			ACT_INIT: begin
				if (!st.busy) begin
					st_next.busy        = 1'b1;
					st_next.query_owner = 1'b0;
					if (item.force_reset) begin
						st_next.init_done    = 1'b0;
						st_next.link_state   = 5'd0;
						st_next.control_copy = CTL_RESET_CMD;
						st_next.phase        = PH_RST_WR;
					end else if (st.init_done) begin
						st_next.phase = PH_UPD_ANAR;
					end else begin
						st_next.poll_count  = 16'd0;
						st_next.status_copy = 16'd0;
						st_next.phase = (cfg.autoneg_poll_limit == 16'd0) ? PH_CTL_RD : PH_AN_TICK;
					end
				end
			end
			ACT_QUERY: begin
				if (!st.busy && (st.link_state == 5'd0 || item.refresh)) begin
					st_next.busy        = 1'b1;
					st_next.query_owner = 1'b1;
					st_next.phase       = PH_UPD_ANAR;
				end
			end
			ACT_RESP: begin
				case (st.phase)
					PH_RST_WR: begin
						st_next.poll_count = 16'd0;
						if (!ok || cfg.reset_poll_limit == 16'd0) begin
							st_next.busy  = 1'b0;
							st_next.phase = PH_IDLE;
						end else begin
							st_next.phase = PH_RST_TICK;
						end
					end
					PH_RST_RD: begin
						if (!ok) begin
							st_next.busy  = 1'b0;
							st_next.phase = PH_IDLE;
						end else begin
							st_next.control_copy = d;
							if (!d[15]) begin
								st_next.poll_count  = 16'd0;
								st_next.status_copy = 16'd0;
								st_next.phase = (cfg.autoneg_poll_limit == 16'd0) ?
									PH_CTL_RD : PH_AN_TICK;
							end else if (rst_done) begin
								st_next.busy  = 1'b0;
								st_next.phase = PH_IDLE;
							end else begin
								st_next.phase = PH_RST_TICK;
							end
						end
					end
					PH_AN_RD: begin
						if (!ok) begin
							st_next.busy  = 1'b0;
							st_next.phase = PH_IDLE;
						end else begin
							st_next.status_copy = d;
							st_next.phase = an_end ? PH_CTL_RD : PH_AN_TICK;
						end
					end
					PH_CTL_RD: begin
						if (!ok) begin
							st_next.busy  = 1'b0;
							st_next.phase = PH_IDLE;
						end else if (!d[9]) begin
							st_next.control_copy = d;
							st_next.poll_count   = 16'd0;
							st_next.status_copy  = 16'd0;
							st_next.phase = (cfg.link_poll_limit == 16'd0) ?
								PH_UPD_ANAR : PH_LU_TICK;
						end else if ((st.status_copy & 16'hA200) != 16'd0) begin
							st_next.control_copy = ctl_100;
							st_next.link_state   = st.link_state | 5'b10010;
							st_next.phase        = PH_RA_WR;
						end else if (st.status_copy[11]) begin
							st_next.control_copy = ctl_10;
							st_next.link_state   = st.link_state | 5'b10100;
							st_next.phase        = PH_RA_WR;
						end else begin
							st_next.control_copy = d;
							st_next.busy         = 1'b0;
							st_next.phase        = PH_IDLE;
						end
					end
					PH_RA_WR: begin
						st_next.poll_count  = 16'd0;
						st_next.status_copy = 16'd0;
						if (cfg.link_poll_limit != 16'd0) begin
							st_next.phase = PH_LU_TICK;
						end else if (st.control_copy[9]) begin
							st_next.init_done = 1'b1;
							st_next.busy      = 1'b0;
							st_next.phase     = PH_IDLE;
						end else begin
							st_next.phase = PH_UPD_ANAR;
						end
					end
					PH_LU_RD: begin
						st_next.status_copy = d;
						if (!lu_end) begin
							st_next.phase = PH_LU_TICK;
						end else if (st.control_copy[9]) begin
							st_next.link_state = st.link_state | {4'd0, d[2]};
							st_next.init_done  = 1'b1;
							st_next.busy       = 1'b0;
							st_next.phase      = PH_IDLE;
						end else begin
							st_next.phase = PH_UPD_ANAR;
						end
					end
					PH_UPD_ANAR, PH_UPD_LPANAR, PH_UPD_STAT: begin
						if (ok && st.phase == PH_UPD_ANAR) begin
							st_next.advert_copy = d;
							st_next.phase       = PH_UPD_LPANAR;
						end else if (ok && st.phase == PH_UPD_LPANAR) begin
							st_next.advert_copy = st.advert_copy & d;
							st_next.phase       = PH_UPD_STAT;
						end else begin
							if (ok) begin
								st_next.status_copy = d;
								st_next.link_state  = resolved;
							end
							st_next.busy  = 1'b0;
							st_next.phase = PH_IDLE;
							if (st.query_owner) begin
								st_next.query_owner = 1'b0;
							end else if (ok || st.init_done) begin
								st_next.init_done = 1'b1;
							end
						end
					end
					default: begin
						st_next = st;
					end
				endcase
			end
			default: begin
				if (st.phase == PH_RST_TICK || st.phase == PH_AN_TICK ||
					st.phase == PH_LU_TICK) begin
					st_next.poll_count = st.poll_count + 16'd1;
					case (st.phase)
						PH_RST_TICK: st_next.phase = PH_RST_RD;
						PH_AN_TICK:  st_next.phase = PH_AN_RD;
						default:     st_next.phase = PH_LU_RD;
					endcase
				end
			end
		endcase
	end

	// Result item.
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		case (item.action)
			ACT_INIT: begin
				res_valid = 1'b1;
				if (st.busy) begin
					res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0, STAT_BUSY, 5'd0);
				end else if (item.force_reset) begin
					res = mk(KIND_MDIO_WR, cfg.phy_address, REG_CONTROL, CTL_RESET_CMD,
						STAT_OK, 5'd0);
				end else if (st.init_done) begin
					res = mk(KIND_MDIO_RD, cfg.phy_address, REG_ANAR, 16'd0, STAT_OK, 5'd0);
				end else if (cfg.autoneg_poll_limit == 16'd0) begin
					res = mk(KIND_MDIO_RD, cfg.phy_address, REG_CONTROL, 16'd0, STAT_OK, 5'd0);
				end else begin
					res_valid = 1'b0;
				end
			end
			ACT_QUERY: begin
				res_valid = 1'b1;
				if (st.busy || !(st.link_state == 5'd0 || item.refresh)) begin
					res = mk(KIND_LINK_REP, cfg.phy_address, REG_CONTROL, 16'd0, STAT_OK,
						st.link_state);
				end else begin
					res = mk(KIND_MDIO_RD, cfg.phy_address, REG_ANAR, 16'd0, STAT_OK, 5'd0);
				end
			end
			ACT_RESP: begin
				case (st.phase)
					PH_RST_WR: begin
						if (!ok || cfg.reset_poll_limit == 16'd0) begin
							res_valid = 1'b1;
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_HW_ERR, 5'd0);
						end
					end
					PH_RST_RD: begin
						if (!ok || (d[15] && rst_done)) begin
							res_valid = 1'b1;
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_HW_ERR, 5'd0);
						end else if (!d[15] && cfg.autoneg_poll_limit == 16'd0) begin
							res_valid = 1'b1;
							res = mk(KIND_MDIO_RD, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_OK, 5'd0);
						end
					end
					PH_AN_RD: begin
						if (!ok) begin
							res_valid = 1'b1;
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_HW_ERR, 5'd0);
						end else if (an_end) begin
							res_valid = 1'b1;
							res = mk(KIND_MDIO_RD, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_OK, 5'd0);
						end
					end
					PH_CTL_RD: begin
						res_valid = 1'b1;
						if (!ok) begin
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_HW_ERR, 5'd0);
						end else if (!d[9]) begin
							res_valid = (cfg.link_poll_limit == 16'd0);
							res = mk(KIND_MDIO_RD, cfg.phy_address, REG_ANAR, 16'd0,
								STAT_OK, 5'd0);
						end else if ((st.status_copy & 16'hA200) != 16'd0) begin
							res = mk(KIND_MDIO_WR, cfg.phy_address, REG_CONTROL, ctl_100,
								STAT_OK, 5'd0);
						end else if (st.status_copy[11]) begin
							res = mk(KIND_MDIO_WR, cfg.phy_address, REG_CONTROL, ctl_10,
								STAT_OK, 5'd0);
						end else begin
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_HW_ERR, 5'd0);
						end
					end
					PH_RA_WR, PH_LU_RD: begin
						if ((st.phase == PH_RA_WR && cfg.link_poll_limit == 16'd0) ||
							(st.phase == PH_LU_RD && lu_end)) begin
							res_valid = 1'b1;
							if (st.control_copy[9]) begin
								res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
									STAT_OK, 5'd0);
							end else begin
								res = mk(KIND_MDIO_RD, cfg.phy_address, REG_ANAR, 16'd0,
									STAT_OK, 5'd0);
							end
						end
					end
					PH_UPD_ANAR, PH_UPD_LPANAR, PH_UPD_STAT: begin
						res_valid = 1'b1;
						if (ok && st.phase == PH_UPD_ANAR) begin
							res = mk(KIND_MDIO_RD, cfg.phy_address, REG_LPANAR, 16'd0,
								STAT_OK, 5'd0);
						end else if (ok && st.phase == PH_UPD_LPANAR) begin
							res = mk(KIND_MDIO_RD, cfg.phy_address, REG_STATUS, 16'd0,
								STAT_OK, 5'd0);
						end else if (st.query_owner) begin
							res = mk(KIND_LINK_REP, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_OK, ok ? resolved : st.link_state);
						end else if (ok || st.init_done) begin
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_OK, 5'd0);
						end else begin
							res = mk(KIND_INIT_STAT, cfg.phy_address, REG_CONTROL, 16'd0,
								STAT_HW_ERR, 5'd0);
						end
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
			default: begin
				res_valid = 1'b1;
				case (st.phase)
					PH_RST_TICK: begin
						res = mk(KIND_MDIO_RD, cfg.phy_address, REG_CONTROL, 16'd0,
							STAT_OK, 5'd0);
					end
					PH_AN_TICK, PH_LU_TICK: begin
						res = mk(KIND_MDIO_RD, cfg.phy_address, REG_STATUS, 16'd0,
							STAT_OK, 5'd0);
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		endcase
	end

endmodule

[sv/phy_link_init_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PHY link init sequencer
// Drives PHY reset, autonegotiation and link resolution over MDIO requests.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Moves
//  in       in_valid in_ready in_data      one event item
//  out      out_valid out_ready out_data   one request, status or reply item
//  cfg      cfg_we cfg_index cfg_wdata     one register write
//
// An accepted item is registered, evaluated from that register, and its result
// is shown from the output register once that register can take it.
// One item is taken per cycle unless the output register stalls, the only
// stall point; a full output register being drained still lets items move.
// Events that cause no result leave no item in the output register.
// Reset clears the sequencer state and restores the register defaults.
// ----------------------------------------------------------------------------
module phy_link_init_sequencer import plis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  plis_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output plis_out_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_wdata
);

	plis_state_t st_q;
	plis_state_t st_d;
	plis_cfg_t   cfg_q;
	logic        valid_s1;
	plis_in_t    item_s1;
	logic        out_valid_q;
	plis_out_t   out_q;
	logic        res_valid;
	plis_out_t   res;
	logic        adv;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	plis_step u_step (
		.st        (st_q),
		.cfg       (cfg_q),
		.item      (item_s1),
		.st_next   (st_d),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PHY_ADDRESS:   cfg_q.phy_address        <= cfg_wdata[4:0];
				CFG_RESET_LIMIT:   cfg_q.reset_poll_limit   <= cfg_wdata;
				CFG_AUTONEG_LIMIT: cfg_q.autoneg_poll_limit <= cfg_wdata;
				default:           cfg_q.link_poll_limit    <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= STATE_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1 && res_valid;
			end
			if (valid_s1 && adv) begin
				st_q <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (adv && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.busy |-> st_q.phase == PH_IDLE)
		else $error("sequencer left idle while not busy");

	a_owner_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.query_owner |-> st_q.busy)
		else $error("query owner set without a running sequence");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(valid_s1))
		else $error("result item appeared without an evaluated item");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(st_q))
		else $error("sequencer state changed without an item");
`endif

endmodule

[dv/tb_phy_link_init_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PHY link init sequencer testbench
// Feeds commands, MDIO responses and ticks to the sequencer, mostly in the
// phases awaiting them, with random response data. Every item it sends goes
// through a cycle-free model of the sequencer. The testbench compares the
// sequencer's results in order against the expected ones, while both
// channels idle and stall at random and the limit registers are swept.
// ----------------------------------------------------------------------------
module tb_phy_link_init_sequencer import plis_pkg::*; ();

	localparam int unsigned SETTLE         = 6;
	localparam int unsigned RX_HOLD        = 400;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned PHASE_ITEMS    = 220;

	localparam logic [15:0] ST_LINK_UP     = 16'h0004;
	localparam logic [15:0] ST_AN_DONE     = 16'h0020;
	localparam logic [15:0] ST_CAP_100     = 16'hA200;
	localparam logic [15:0] ST_CAP_10_HALF = 16'h0800;
	localparam logic [15:0] CTL_RESTART_AN = 16'h0200;
	localparam logic [15:0] CTL_SPEED_100  = 16'h2000;
	localparam logic [15:0] CTL_SPEED_BIT6 = 16'h0040;
	localparam logic [15:0] ADV_100        = 16'h0180;
	localparam logic [15:0] ADV_10         = 16'h0060;
	localparam logic [15:0] ADV_FULL       = 16'h0140;
	localparam logic [15:0] ADV_HALF       = 16'h00A0;
	localparam logic [4:0]  LF_ACTIVE      = 5'd1;
	localparam logic [4:0]  LF_100         = 5'd2;
	localparam logic [4:0]  LF_10          = 5'd4;
	localparam logic [4:0]  LF_FULL        = 5'd8;
	localparam logic [4:0]  LF_HALF        = 5'd16;

	localparam plis_out_t NO_ITEM = '0;

	typedef enum logic [1:0] {
		PREDICTED  = 2'd0,
		TYPED      = 2'd1,
		TYPED_NONE = 2'd2
	} row_chk_t;

	typedef struct packed {
		plis_in_t  ev;
		row_chk_t  how;
		plis_out_t res;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	plis_in_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	plis_out_t  out_data;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_PHY_ADDRESS;
	logic [15:0] cfg_wdata = 16'd0;

	logic [4:0]  set_phy = 5'd1;
	logic [15:0] set_rst_lim = 16'd1000;
	logic [15:0] set_an_lim = 16'd6000;
	logic [15:0] set_lu_lim = 16'd1000;

	phase_t      seq_phase = PH_IDLE;
	logic [15:0] seq_polls = 16'd0;
	logic [15:0] seq_ctl = 16'd0;
	logic [15:0] seq_stat = 16'd0;
	logic [15:0] seq_adv = 16'd0;
	logic [4:0]  seq_link = 5'd0;
	bit          seq_inited = 1'b0;
	bit          seq_busy = 1'b0;
	bit          seq_for_query = 1'b0;
	bit          seq_has;
	plis_out_t   seq_res;

	plis_out_t due_items [$];
	dir_row_t  dir_rows [$];
	int        n_errors = 0;
	int        quiet_cycles = 0;
	bit        calm = 1'b0;
	bit        hold_rx = 1'b0;

	phy_link_init_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic void emit_item(kind_t k, logic [4:0] ra, logic [15:0] wd,
			init_status_t st, logic [4:0] fl);
		bit mdio;
		mdio = (k == KIND_MDIO_RD) || (k == KIND_MDIO_WR);
		seq_has = 1'b1;
		seq_res.kind       = k;
		seq_res.dev_addr   = mdio ? set_phy : 5'd0;
		seq_res.reg_addr   = mdio ? ra : 5'd0;
		seq_res.write_data = (k == KIND_MDIO_WR) ? wd : 16'd0;
		seq_res.status     = (k == KIND_INIT_STAT) ? st : STAT_OK;
		seq_res.link_flags = (k == KIND_LINK_REP) ? fl : 5'd0;
	endfunction

	function automatic void init_fails();
		seq_busy = 1'b0;
		seq_phase = PH_IDLE;
		emit_item(KIND_INIT_STAT, REG_CONTROL, 16'd0, STAT_HW_ERR, 5'd0);
	endfunction

	function automatic void init_succeeds();
		seq_inited = 1'b1;
		seq_busy = 1'b0;
		seq_phase = PH_IDLE;
		emit_item(KIND_INIT_STAT, REG_CONTROL, 16'd0, STAT_OK, 5'd0);
	endfunction

	function automatic void close_refresh(bit ok);
		if (seq_for_query) begin
			seq_for_query = 1'b0;
			seq_busy = 1'b0;
			seq_phase = PH_IDLE;
			emit_item(KIND_LINK_REP, REG_CONTROL, 16'd0, STAT_OK, seq_link);
		end else if (ok || seq_inited) begin
			init_succeeds();
		end else begin
			init_fails();
		end
	endfunction

	function automatic void start_refresh();
		seq_phase = PH_UPD_ANAR;
		emit_item(KIND_MDIO_RD, REG_ANAR, 16'd0, STAT_OK, 5'd0);
	endfunction

	function automatic void start_autoneg_wait();
		seq_polls = 16'd0;
		seq_stat = 16'd0;
		if (set_an_lim == 16'd0) begin
			seq_phase = PH_CTL_RD;
			emit_item(KIND_MDIO_RD, REG_CONTROL, 16'd0, STAT_OK, 5'd0);
		end else begin
			seq_phase = PH_AN_TICK;
		end
	endfunction

	function automatic void end_link_wait();
		if ((seq_ctl & CTL_RESTART_AN) != 16'd0) begin
			if ((seq_stat & ST_LINK_UP) != 16'd0)
				seq_link = seq_link | LF_ACTIVE;
			init_succeeds();
		end else begin
			start_refresh();
		end
	endfunction

	function automatic void start_link_wait();
		seq_polls = 16'd0;
		seq_stat = 16'd0;
		if (set_lu_lim == 16'd0)
			end_link_wait();
		else
			seq_phase = PH_LU_TICK;
	endfunction

	function automatic bit waiting_tick();
		return seq_phase == PH_RST_TICK || seq_phase == PH_AN_TICK || seq_phase == PH_LU_TICK;
	endfunction

	function automatic void take_response(bit ok, logic [15:0] d);
		logic [4:0] flags;
		case (seq_phase)
			PH_RST_WR: begin
				if (!ok) begin
					init_fails();
				end else begin
					seq_polls = 16'd0;
					if (set_rst_lim == 16'd0)
						init_fails();
					else
						seq_phase = PH_RST_TICK;
				end
			end
			PH_RST_RD: begin
				if (!ok) begin
					init_fails();
				end else begin
					seq_ctl = d;
					if ((d & CTL_RESET_CMD) == 16'd0)
						start_autoneg_wait();
					else if (seq_polls >= set_rst_lim)
						init_fails();
					else
						seq_phase = PH_RST_TICK;
				end
			end
			PH_AN_RD: begin
				if (!ok) begin
					init_fails();
				end else begin
					seq_stat = d;
					if ((d & ST_AN_DONE) != 16'd0 || seq_polls >= set_an_lim) begin
						seq_phase = PH_CTL_RD;
						emit_item(KIND_MDIO_RD, REG_CONTROL, 16'd0, STAT_OK, 5'd0);
					end else begin
						seq_phase = PH_AN_TICK;
					end
				end
			end
			PH_CTL_RD: begin
				if (!ok) begin
					init_fails();
				end else begin
					seq_ctl = d;
					if ((d & CTL_RESTART_AN) == 16'd0) begin
						start_link_wait();
					end else if ((seq_stat & ST_CAP_100) != 16'd0) begin
						seq_ctl = (seq_ctl | CTL_SPEED_100) & ~CTL_SPEED_BIT6;
						seq_link = seq_link | LF_100 | LF_HALF;
						seq_phase = PH_RA_WR;
						emit_item(KIND_MDIO_WR, REG_CONTROL, seq_ctl, STAT_OK, 5'd0);
					end else if ((seq_stat & ST_CAP_10_HALF) != 16'd0) begin
						seq_ctl = (seq_ctl & ~CTL_SPEED_100) | CTL_SPEED_BIT6;
						seq_link = seq_link | LF_10 | LF_HALF;
						seq_phase = PH_RA_WR;
						emit_item(KIND_MDIO_WR, REG_CONTROL, seq_ctl, STAT_OK, 5'd0);
					end else begin
						init_fails();
					end
				end
			end
			PH_RA_WR: begin
				start_link_wait();
			end
			PH_LU_RD: begin
				seq_stat = d;
				if (!ok || (d & ST_LINK_UP) != 16'd0 || seq_polls >= set_lu_lim)
					end_link_wait();
				else
					seq_phase = PH_LU_TICK;
			end
			PH_UPD_ANAR: begin
				if (!ok) begin
					close_refresh(1'b0);
				end else begin
					seq_adv = d;
					seq_phase = PH_UPD_LPANAR;
					emit_item(KIND_MDIO_RD, REG_LPANAR, 16'd0, STAT_OK, 5'd0);
				end
			end
			PH_UPD_LPANAR: begin
				if (!ok) begin
					close_refresh(1'b0);
				end else begin
					seq_adv = seq_adv & d;
					seq_phase = PH_UPD_STAT;
					emit_item(KIND_MDIO_RD, REG_STATUS, 16'd0, STAT_OK, 5'd0);
				end
			end
			PH_UPD_STAT: begin
				if (!ok) begin
					close_refresh(1'b0);
				end else begin
					seq_stat = d;
					flags = 5'd0;
					if ((seq_adv & ADV_100) != 16'd0)
						flags = flags | LF_100;
					else if ((seq_adv & ADV_10) != 16'd0)
						flags = flags | LF_10;
					if ((seq_adv & ADV_FULL) != 16'd0)
						flags = flags | LF_FULL;
					else if ((seq_adv & ADV_HALF) != 16'd0)
						flags = flags | LF_HALF;
					if ((d & ST_LINK_UP) != 16'd0)
						flags = flags | LF_ACTIVE;
					seq_link = flags;
					close_refresh(1'b1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void take_tick();
		if (waiting_tick()) begin
			seq_polls = seq_polls + 16'd1;
			case (seq_phase)
				PH_RST_TICK: begin
					seq_phase = PH_RST_RD;
					emit_item(KIND_MDIO_RD, REG_CONTROL, 16'd0, STAT_OK, 5'd0);
				end
				PH_AN_TICK: begin
					seq_phase = PH_AN_RD;
					emit_item(KIND_MDIO_RD, REG_STATUS, 16'd0, STAT_OK, 5'd0);
				end
				default: begin
					seq_phase = PH_LU_RD;
					emit_item(KIND_MDIO_RD, REG_STATUS, 16'd0, STAT_OK, 5'd0);
				end
			endcase
		end
	endfunction

	function automatic void advance_sequencer(plis_in_t ev);
		seq_has = 1'b0;
		seq_res = '0;
		case (ev.action)
			ACT_INIT: begin
				if (seq_busy) begin
					emit_item(KIND_INIT_STAT, REG_CONTROL, 16'd0, STAT_BUSY, 5'd0);
				end else begin
					seq_busy = 1'b1;
					seq_for_query = 1'b0;
					if (ev.force_reset) begin
						seq_inited = 1'b0;
						seq_link = 5'd0;
						seq_ctl = CTL_RESET_CMD;
						seq_phase = PH_RST_WR;
						emit_item(KIND_MDIO_WR, REG_CONTROL, CTL_RESET_CMD, STAT_OK, 5'd0);
					end else if (seq_inited) begin
						start_refresh();
					end else begin
						start_autoneg_wait();
					end
				end
			end
			ACT_QUERY: begin
				if (seq_busy || !(seq_link == 5'd0 || ev.refresh)) begin
					emit_item(KIND_LINK_REP, REG_CONTROL, 16'd0, STAT_OK, seq_link);
				end else begin
					seq_busy = 1'b1;
					seq_for_query = 1'b1;
					start_refresh();
				end
			end
			ACT_RESP: take_response(ev.mdio_ok, ev.mdio_data);
			default: take_tick();
		endcase
	endfunction

	function automatic plis_in_t mk_ev(action_t a, bit frc, bit rfr, bit ok, logic [15:0] d);
		plis_in_t ev;
		ev.action = a;
		ev.force_reset = frc;
		ev.refresh = rfr;
		ev.mdio_ok = ok;
		ev.mdio_data = d;
		return ev;
	endfunction

	function automatic plis_out_t mk_res(kind_t k, logic [4:0] pa, logic [4:0] ra,
			logic [15:0] wd, init_status_t st, logic [4:0] fl);
		plis_out_t res;
		res.kind = k;
		res.dev_addr = pa;
		res.reg_addr = ra;
		res.write_data = wd;
		res.status = st;
		res.link_flags = fl;
		return res;
	endfunction

	function automatic plis_in_t next_event();
		plis_in_t ev;
		logic [31:0] r;
		logic [31:0] d;
		r = $urandom;
		ev = r[$bits(plis_in_t)-1:0];
		if ($urandom_range(0, 99) < 12)
			return ev;
		if (seq_phase == PH_IDLE) begin
			ev.action = ($urandom_range(0, 2) == 0) ? ACT_QUERY : ACT_INIT;
		end else if (waiting_tick()) begin
			if ($urandom_range(0, 9) == 0)
				ev.action = r[31] ? ACT_INIT : ACT_QUERY;
			else
				ev.action = ACT_TICK;
		end else begin
			case ($urandom_range(0, 3))
				0: d = $urandom & $urandom & $urandom;
				1: d = $urandom | $urandom;
				default: d = $urandom;
			endcase
			ev.action = ACT_RESP;
			ev.mdio_ok = ($urandom_range(0, 15) != 0);
			ev.mdio_data = d[15:0];
		end
		return ev;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic string show(plis_out_t v);
		return $sformatf("kind %0d phy %0d reg %0d data %h status %0d flags %h",
			v.kind, v.dev_addr, v.reg_addr, v.write_data, v.status, v.link_flags);
	endfunction

	task automatic report_mismatch(input string why, input plis_out_t want, input plis_out_t got);
		n_errors++;
		if (n_errors <= 10) begin
			$display("mismatch at %0t:%0s", $time, why);
			$display("  expected %0s", show(want));
			$display("  actual   %0s", show(got));
		end
	endtask

	task automatic offer(input plis_in_t ev, input row_chk_t how, input plis_out_t typed);
		int unsigned n_gap;
		in_valid <= 1'b1;
		in_data <= ev;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_sequencer(ev);
		if (how == TYPED)
			due_items.push_back(typed);
		else if (how == PREDICTED && seq_has)
			due_items.push_back(seq_res);
		n_gap = idle_gap();
		if (n_gap > 0) begin
			in_valid <= 1'b0;
			repeat (n_gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_items.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_settings(input logic [4:0] pa, input logic [15:0] rl,
			input logic [15:0] al, input logic [15:0] ll);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PHY_ADDRESS;
		cfg_wdata <= {11'd0, pa};
		@(posedge clk);
		cfg_index <= CFG_RESET_LIMIT;
		cfg_wdata <= rl;
		@(posedge clk);
		cfg_index <= CFG_AUTONEG_LIMIT;
		cfg_wdata <= al;
		@(posedge clk);
		cfg_index <= CFG_LINK_LIMIT;
		cfg_wdata <= ll;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_phy = pa;
		set_rst_lim = rl;
		set_an_lim = al;
		set_lu_lim = ll;
	endtask

	always @(posedge clk) begin : result_check
		plis_out_t want;
		string bad;
		if (arst_n && out_valid && out_ready) begin
			if (due_items.size() == 0) begin
				report_mismatch(" no result was due", NO_ITEM, out_data);
			end else begin
				want = due_items.pop_front();
				bad = "";
				if (out_data.kind !== want.kind)
					bad = {bad, " kind"};
				if (out_data.dev_addr !== want.dev_addr)
					bad = {bad, " dev_addr"};
				if (out_data.reg_addr !== want.reg_addr)
					bad = {bad, " reg_addr"};
				if (out_data.write_data !== want.write_data)
					bad = {bad, " write_data"};
				if (out_data.status !== want.status)
					bad = {bad, " status"};
				if (out_data.link_flags !== want.link_flags)
					bad = {bad, " link_flags"};
				if (bad != "")
					report_mismatch(bad, want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		int unsigned len;
		bit rdy;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				rdy = 1'b0;
				len = RX_HOLD;
			end else begin
				len = idle_gap();
				rdy = (len == 0);
				if (rdy)
					len = $urandom_range(1, 12);
			end
			out_ready <= rdy;
			repeat (len) @(posedge clk);
		end
	end

	initial begin : stimulus
		plis_in_t ev;
		bit stray;
		int unsigned counted;
		dir_rows.push_back({mk_ev(ACT_QUERY, 1'b0, 1'b0, 1'b0, 16'h0000), TYPED,
			mk_res(KIND_MDIO_RD, 5'd1, REG_ANAR, 16'd0, STAT_OK, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'hFFFF), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h01E0), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h0004), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_TICK, 1'b1, 1'b1, 1'b1, 16'hFFFF), TYPED_NONE, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_INIT, 1'b1, 1'b0, 1'b0, 16'h0000), TYPED,
			mk_res(KIND_MDIO_WR, 5'd1, REG_CONTROL, CTL_RESET_CMD, STAT_OK, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_INIT, 1'b0, 1'b0, 1'b0, 16'h0000), TYPED,
			mk_res(KIND_INIT_STAT, 5'd0, 5'd0, 16'd0, STAT_BUSY, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_QUERY, 1'b0, 1'b1, 1'b0, 16'h0000), TYPED,
			mk_res(KIND_LINK_REP, 5'd0, 5'd0, 16'd0, STAT_OK, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h8000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h3200), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'hFFFF), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h1200), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b0, 16'h0004), TYPED,
			mk_res(KIND_INIT_STAT, 5'd0, 5'd0, 16'd0, STAT_OK, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_INIT, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_INIT, 1'b1, 1'b0, 1'b0, 16'h0000), TYPED,
			mk_res(KIND_MDIO_WR, 5'd1, REG_CONTROL, CTL_RESET_CMD, STAT_OK, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b0, 16'h0000), TYPED,
			mk_res(KIND_INIT_STAT, 5'd0, 5'd0, 16'd0, STAT_HW_ERR, 5'd0)});
		dir_rows.push_back({mk_ev(ACT_INIT, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h0020), PREDICTED, NO_ITEM});
		dir_rows.push_back({mk_ev(ACT_RESP, 1'b0, 1'b0, 1'b1, 16'h0200), TYPED,
			mk_res(KIND_INIT_STAT, 5'd0, 5'd0, 16'd0, STAT_HW_ERR, 5'd0)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].ev, dir_rows[i].how, dir_rows[i].res);
		drain_results();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: write_settings(5'd31, 16'd1, 16'd1, 16'd1);
				2: write_settings(5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: write_settings(5'($urandom_range(0, 31)), 16'($urandom_range(1, 4)),
					16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
				4: write_settings(5'($urandom_range(0, 31)), 16'($urandom_range(1, 20)),
					16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
				default: begin
				end
			endcase
			calm = (ph == 2);
			if (ph == 1 || ph == 3)
				hold_rx = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				ev = next_event();
				stray = (ev.action == ACT_RESP && (seq_phase == PH_IDLE || waiting_tick()))
					|| (ev.action == ACT_TICK && !waiting_tick());
				offer(ev, PREDICTED, NO_ITEM);
				if (!stray) begin
					counted++;
					if (counted == 100)
						drain_results();
				end
				if ($urandom_range(0, 199) == 0)
					drain_results();
			end
			drain_results();
		end

		if (n_errors == 0 && due_items.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
